// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the genset autostart sequencer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_PROP(lbl, !(cond), msg)

`endif

// ===== hw/rtl/gas_pkg.sv =====
// Shared types and constants for the genset autostart sequencer.
// Depends on nothing; imported by every module of the block.
package gas_pkg;

    localparam int RpmW     = 13;
    localparam int CntW     = 8;
    localparam int AttW     = 4;
    localparam int CodeW    = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 13;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CRANK_TIMEOUT = 3'd0;
    localparam t_cfg_idx CFG_MAX_ATTEMPTS  = 3'd1;
    localparam t_cfg_idx CFG_STARTED_RPM   = 3'd2;
    localparam t_cfg_idx CFG_WARMUP_TARGET = 3'd3;
    localparam t_cfg_idx CFG_COOL_TARGET   = 3'd4;

    localparam logic [CntW-1:0] RstCrankTimeout = 8'd3;
    localparam logic [AttW-1:0] RstMaxAttempts  = 4'd3;
    localparam logic [RpmW-1:0] RstStartedRpm   = 13'd300;
    localparam logic [CntW-1:0] RstWarmupTarget = 8'd2;
    localparam logic [CntW-1:0] RstCoolTarget   = 8'd2;

    typedef enum logic [CodeW-1:0] {
        CMD_STOP    = 3'd0,
        CMD_OPEN    = 3'd1,
        CMD_COOL    = 3'd2,
        CMD_PREHEAT = 3'd3,
        CMD_CRANK   = 3'd4,
        CMD_CLOSE   = 3'd5
    } t_cmd;

    typedef enum logic [CodeW-1:0] {
        FLT_NONE      = 3'd0,
        FLT_ESTOP     = 3'd1,
        FLT_OIL       = 3'd2,
        FLT_BATT      = 3'd3,
        FLT_STARTFAIL = 3'd4
    } t_fault;

    typedef struct packed {
        logic [CntW-1:0] crank_timeout;
        logic [AttW-1:0] max_attempts;
        logic [RpmW-1:0] started_rpm;
        logic [CntW-1:0] warmup_target;
        logic [CntW-1:0] cool_target;
    } t_cfg;

    typedef struct packed {
        logic            estop;
        logic            reset_req;
        logic            utility;
        logic [RpmW-1:0] rpm;
        logic            oil_ok;
        logic            batt_ok;
    } t_tick;

    typedef struct packed {
        logic [CodeW-1:0] gen_state;
        t_cmd             cmd;
        t_fault           fault;
        logic [AttW-1:0]  attempts;
        logic             closed;
    } t_result;

endpackage

// ===== hw/rtl/gas_cfg_regs.sv =====
// Configuration register file of the genset autostart sequencer.
// Depends on gas_pkg.
module gas_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  gas_pkg::t_cfg_idx             i_cfg_index,
    input  logic [gas_pkg::CfgDataW-1:0]  i_cfg_data,
    output gas_pkg::t_cfg                 o_cfg
);
    import gas_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crank_timeout <= RstCrankTimeout;
            r_cfg.max_attempts  <= RstMaxAttempts;
            r_cfg.started_rpm   <= RstStartedRpm;
            r_cfg.warmup_target <= RstWarmupTarget;
            r_cfg.cool_target   <= RstCoolTarget;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CRANK_TIMEOUT: r_cfg.crank_timeout <= i_cfg_data[CntW-1:0];
                CFG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_data[AttW-1:0];
                CFG_STARTED_RPM:   r_cfg.started_rpm   <= i_cfg_data[RpmW-1:0];
                CFG_WARMUP_TARGET: r_cfg.warmup_target <= i_cfg_data[CntW-1:0];
                CFG_COOL_TARGET:   r_cfg.cool_target   <= i_cfg_data[CntW-1:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/gas_seq_core.sv =====
// Sequencer state and next-state logic of the genset autostart sequencer.
// Depends on gas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gas_seq_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  gas_pkg::t_tick   i_tick,
    input  gas_pkg::t_cfg    i_cfg,
    output gas_pkg::t_result o_res
);
    import gas_pkg::*;

    typedef enum logic [CodeW-1:0] {
        M_IDLE  = 3'd0,
        M_DELAY = 3'd1,
        M_CRANK = 3'd2,
        M_WARM  = 3'd3,
        M_RUN   = 3'd4,
        M_COOL  = 3'd5,
        M_FAULT = 3'd6
    } t_mode;

    localparam logic [AttW-1:0] AttMax = '1;
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    t_mode           r_mode,     n_mode;
    t_fault          r_held,     n_held;
    logic [AttW-1:0] r_attempts, n_attempts;
    logic [CntW-1:0] r_crank,    n_crank;
    logic [CntW-1:0] r_warm,     n_warm;
    logic [CntW-1:0] r_cool,     n_cool;
    t_cmd            res_cmd;
    t_fault          res_fault;
    logic            res_closed;
    logic            started;
    logic            rpm_zero;
    logic [CntW-1:0] warm_inc;

    assign started  = i_tick.rpm >= i_cfg.started_rpm;
    assign rpm_zero = i_tick.rpm == '0;
    assign warm_inc = r_warm + CntOne;

    always_comb begin
        n_mode     = r_mode;
        n_held     = r_held;
        n_attempts = r_attempts;
        n_crank    = r_crank;
        n_warm     = r_warm;
        n_cool     = r_cool;
        res_cmd    = CMD_STOP;
        res_fault  = FLT_NONE;
        res_closed = 1'b0;

        if (i_tick.estop) begin
            n_mode    = M_FAULT;
            n_held    = FLT_ESTOP;
            n_crank   = '0;
            n_warm    = '0;
            n_cool    = '0;
            res_fault = FLT_ESTOP;
        end else if (r_mode == M_FAULT) begin
            if (i_tick.reset_req && i_tick.utility && rpm_zero) begin
                n_mode     = M_IDLE;
                n_held     = FLT_NONE;
                n_attempts = '0;
                res_cmd    = CMD_OPEN;
            end else begin
                res_fault = r_held;
            end
        end else if ((r_mode == M_WARM || r_mode == M_RUN) && !i_tick.oil_ok) begin
            n_mode    = M_FAULT;
            n_held    = FLT_OIL;
            n_crank   = '0;
            n_warm    = '0;
            n_cool    = '0;
            res_fault = FLT_OIL;
        end else if (i_tick.utility) begin
            // Mains back: wind down whatever is in progress.
            if (r_mode == M_RUN || r_mode == M_WARM || r_mode == M_CRANK ||
                r_mode == M_DELAY) begin
                n_mode  = M_COOL;
                n_cool  = CntOne;
                res_cmd = CMD_COOL;
            end else if (r_mode == M_COOL) begin
                if (rpm_zero || r_cool >= i_cfg.cool_target) begin
                    n_mode     = M_IDLE;
                    n_attempts = '0;
                    n_cool     = '0;
                    res_cmd    = CMD_OPEN;
                end else begin
                    n_cool  = r_cool + CntOne;
                    res_cmd = CMD_COOL;
                end
            end else begin
                n_mode     = M_IDLE;
                n_held     = FLT_NONE;
                n_attempts = '0;
                res_cmd    = CMD_OPEN;
            end
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                    if (!i_tick.batt_ok) begin
                        n_mode    = M_FAULT;
                        n_held    = FLT_BATT;
                        n_crank   = '0;
                        n_warm    = '0;
                        n_cool    = '0;
                        res_fault = FLT_BATT;
                    end else begin
                        n_mode  = M_DELAY;
                        res_cmd = CMD_PREHEAT;
                    end
                end
                M_DELAY: begin
                    if (!i_tick.batt_ok) begin
                        n_mode    = M_FAULT;
                        n_held    = FLT_BATT;
                        n_crank   = '0;
                        n_warm    = '0;
                        n_cool    = '0;
                        res_fault = FLT_BATT;
                    end else begin
                        n_mode = M_CRANK;
                        if (r_attempts != AttMax) begin
                            n_attempts = r_attempts + AttW'(1);
                        end
                        n_crank = CntOne;
                        res_cmd = CMD_CRANK;
                    end
                end
                M_CRANK: begin
                    if (started) begin
                        n_mode  = M_WARM;
                        n_warm  = CntOne;
                        n_crank = '0;
                        res_cmd = CMD_OPEN;
                    end else if (!i_tick.batt_ok) begin
                        n_mode    = M_FAULT;
                        n_held    = FLT_BATT;
                        n_crank   = '0;
                        n_warm    = '0;
                        n_cool    = '0;
                        res_fault = FLT_BATT;
                    end else if (r_crank >= i_cfg.crank_timeout) begin
                        n_crank = '0;
                        if (r_attempts >= i_cfg.max_attempts) begin
                            n_mode    = M_FAULT;
                            n_held    = FLT_STARTFAIL;
                            n_warm    = '0;
                            n_cool    = '0;
                            res_fault = FLT_STARTFAIL;
                        end else begin
                            n_mode  = M_DELAY;
                            res_cmd = CMD_PREHEAT;
                        end
                    end else begin
                        n_crank = r_crank + CntOne;
                        res_cmd = CMD_CRANK;
                    end
                end
                M_WARM: begin
                    if (!started) begin
                        n_mode    = M_FAULT;
                        n_held    = FLT_STARTFAIL;
                        n_crank   = '0;
                        n_warm    = '0;
                        n_cool    = '0;
                        res_fault = FLT_STARTFAIL;
                    end else if (warm_inc >= i_cfg.warmup_target) begin
                        n_mode     = M_RUN;
                        res_cmd    = CMD_CLOSE;
                        res_closed = 1'b1;
                    end else begin
                        n_warm  = warm_inc;
                        res_cmd = CMD_OPEN;
                    end
                end
                M_RUN: begin
                    res_cmd    = CMD_CLOSE;
                    res_closed = 1'b1;
                end
                M_COOL: begin
                    n_cool  = CntOne;
                    res_cmd = CMD_COOL;
                end
                default: begin
                    res_fault = r_held;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_held     <= FLT_NONE;
            r_attempts <= '0;
            r_crank    <= '0;
            r_warm     <= '0;
            r_cool     <= '0;
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_held     <= n_held;
            r_attempts <= n_attempts;
            r_crank    <= n_crank;
            r_warm     <= n_warm;
            r_cool     <= n_cool;
        end
    end

    assign o_res.gen_state = n_mode;
    assign o_res.cmd       = res_cmd;
    assign o_res.fault     = res_fault;
    assign o_res.attempts  = n_attempts;
    assign o_res.closed    = res_closed;

    `ASSERT_PROP(a_attempts_monotonic,
        1'b1 |=> (r_attempts == '0 || r_attempts >= $past(r_attempts)),
        "attempt count dropped without a clear")
    `ASSERT_NEVER(a_fault_counters_clear,
        r_mode == M_FAULT && (r_crank != '0 || r_warm != '0 || r_cool != '0),
        "tick counters live in latched fault")
    `ASSERT_NEVER(a_held_clear_outside_fault,
        r_mode != M_FAULT && r_held != FLT_NONE,
        "fault code held outside latched fault")

endmodule

// ===== hw/rtl/generator_autostart_sequencer_unit.sv =====
// Top level of the genset autostart sequencer: input register, sequencer core,
// result register and configuration registers. Depends on gas_pkg,
// gas_cfg_regs, gas_seq_core and assert_macros.svh.
//
// One input beat is one control tick. A tick sits in the input register, the
// sequencer core resolves it in combinational next-state logic (one compare
// per tick counter) and the result beat lands in the result register, so the
// block takes one tick per clock while no result beat is stalled, and a result
// beat is presented in the cycle after its tick advances. The only limit on rate
// is the output side: while a result beat is stalled the tick behind it holds in
// the input register, and a third tick is stalled. Configuration registers are
// written with i_cfg_we and must only be changed while no tick is in flight.
`include "assert_macros.svh"

module generator_autostart_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  gas_pkg::t_cfg_idx             i_cfg_index,
    input  logic [gas_pkg::CfgDataW-1:0]  i_cfg_data,
    // tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_emergency_stop,
    input  logic                          i_reset_request,
    input  logic                          i_utility_present,
    input  logic [gas_pkg::RpmW-1:0]      i_engine_rpm,
    input  logic                          i_oil_ok,
    input  logic                          i_battery_ok,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gas_pkg::CodeW-1:0]     o_gen_state,
    output logic [gas_pkg::CodeW-1:0]     o_command_code,
    output logic [gas_pkg::CodeW-1:0]     o_fault_code,
    output logic [gas_pkg::AttW-1:0]      o_attempt_count,
    output logic                          o_load_connected
);
    import gas_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    logic    r_in_valid;
    t_tick   r_tick;
    logic    r_out_valid;
    t_result r_res;

    // The core advances when a tick is held and the result register is free
    // or being emptied this cycle.
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    gas_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gas_seq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_tick  (r_tick),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Input register: load a new beat whenever the slot is empty or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_tick.estop     <= i_emergency_stop;
            r_tick.reset_req <= i_reset_request;
            r_tick.utility   <= i_utility_present;
            r_tick.rpm       <= i_engine_rpm;
            r_tick.oil_ok    <= i_oil_ok;
            r_tick.batt_ok   <= i_battery_ok;
        end
    end

    // Result register: capture on advance, drop once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_gen_state        = r_res.gen_state;
    assign o_command_code     = r_res.cmd;
    assign o_fault_code       = r_res.fault;
    assign o_attempt_count    = r_res.attempts;
    assign o_load_connected   = r_res.closed;

    `ASSERT_PROP(a_advance_fills_result, advance |=> r_out_valid,
        "processed tick produced no result beat")
    `ASSERT_PROP(a_contactor_matches_cmd,
        r_out_valid |-> (r_res.closed == (r_res.cmd == CMD_CLOSE)),
        "contactor flag disagrees with close command")
    `ASSERT_PROP(a_fault_means_stop,
        (r_out_valid && r_res.fault != FLT_NONE) |-> (r_res.cmd == CMD_STOP),
        "fault reported without stop command")

endmodule
